@@ hdl/alr_pkg.sv @@
package alr_pkg;

  // sample format
  localparam int SAMPLE_W = 16;
  localparam int PEAK_W   = SAMPLE_W + 1;

  // fixed port field widths
  localparam int CAP_W     = 21;
  localparam int PLAYHD_W  = 20;
  localparam int LEN_W     = 21;
  localparam int STATE_W   = 3;
  localparam int CMD_W     = 3;

  // stream bus widths
  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 4;
  localparam int OUT_DATA_W = 96;

  localparam logic [CAP_W-1:0] CAP_RESET = 21'd1048576;

  // looper modes
  localparam logic [STATE_W-1:0] MODE_EMPTY = 3'd0;
  localparam logic [STATE_W-1:0] MODE_REC   = 3'd1;
  localparam logic [STATE_W-1:0] MODE_STOP  = 3'd2;
  localparam logic [STATE_W-1:0] MODE_PLAY  = 3'd3;
  localparam logic [STATE_W-1:0] MODE_ODUB  = 3'd4;

  // commands
  localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_RECORD  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_STOP    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PLAY    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_OVERDUB = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd5;
  localparam logic [CMD_W-1:0] CMD_MONITOR = 3'd6;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SAMPLE_W:0]   wide_sample_t;
  typedef logic [PEAK_W-1:0]          peak_t;

  // clamp a one-bit-grown sum back to the sample range
  function automatic sample_t sat_sample(input wide_sample_t v);
    sample_t r;
    if (v[SAMPLE_W] != v[SAMPLE_W-1]) begin
      r = v[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

  // absolute value, one bit wider so that the most negative sample fits
  function automatic peak_t mag_sample(input sample_t v);
    wide_sample_t w;
    w = {v[SAMPLE_W-1], v};
    return w[SAMPLE_W] ? peak_t'(-w) : peak_t'(w);
  endfunction

endpackage

@@ hdl/audio_loop_recorder_unit.sv @@
// an input transfer fills the read stage, which feeds the output register that offers the result
// throughput: one item per cycle unless the output stalls, using one memory read and one write port
// overdub writes back in the second stage; a same-entry read behind it is forwarded
// reset: sync active-low rst_n clears mode, counts, peaks, pipeline; capacity to CAP_RESET
// the loop memory is not cleared; entries are only played back after the recording wrote them
module audio_loop_recorder_unit #(
  parameter int LOOP_DEPTH = 1048576
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration: capacity_frames
  input  logic                           cfg_wen,
  input  logic [alr_pkg::CAP_W-1:0]      cfg_wdata,
  // in_tdata: in_sample[15:0], flag[16], zero[23:17]
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [alr_pkg::IN_DATA_W-1:0]  in_tdata,
  // in_tuser: cmd[2:0], block_start[3]
  input  logic [alr_pkg::IN_USER_W-1:0]  in_tuser,
  // out_tdata: out_sample[15:0], looper_state[18:16], input_peak[34:19],
  // output_peak[50:35], playhead[70:51], loop_length[91:71], monitoring[92], zero[95:93]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [alr_pkg::OUT_DATA_W-1:0] out_tdata
);
  import alr_pkg::*;

  localparam int AW    = (LOOP_DEPTH > 1) ? $clog2(LOOP_DEPTH) : 1;
  localparam int CNT_W = $clog2(LOOP_DEPTH + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // control state
  logic [STATE_W-1:0] mode_r, mode_nxt;
  logic               mon_r, mon_nxt;
  logic [CNT_W-1:0]   rec_cnt_r, rec_cnt_nxt;
  logic [CNT_W-1:0]   final_len_r, final_len_nxt;
  logic [AW-1:0]      pos_r, pos_nxt;
  logic [CAP_W-1:0]   cap_r;
  peak_t              in_peak_r, in_peak_nxt;
  peak_t              out_peak_r, out_peak_nxt;

  // loop memory
  sample_t loop_mem [LOOP_DEPTH];
  sample_t rd_data_r;
  logic    fwd_r;
  sample_t fwd_data_r;

  // read stage registers
  logic               s1_valid_r;
  logic               s1_tick_r;
  logic               s1_bs_r;
  sample_t            s1_x_r;
  sample_t            s1_add_r;
  logic               s1_pb_en_r;
  logic               s1_wr_r;
  logic               s1_wr_odub_r;
  logic [AW-1:0]      s1_addr_r;
  logic [STATE_W-1:0] s1_mode_r;
  logic               s1_mon_r;
  logic [CNT_W-1:0]   s1_final_r;
  logic [AW-1:0]      s1_pos_r;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // input fields
  logic [CMD_W-1:0] cmd;
  logic             blk_start;
  sample_t          x;
  logic             flag;

  // stage-one decisions
  sample_t       add_a;
  logic          pb_en_a;
  logic          wr_a;
  logic          wr_odub_a;
  logic [AW-1:0] addr_a;

  logic [CMP_W-1:0] cap_eff;
  logic [CMP_W-1:0] cnt_ext;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] fin_ext;
  logic [CMP_W-1:0] pos_inc;
  logic [AW-1:0]    pos_adv;

  logic    in_fire;
  logic    s1_fire;
  sample_t pb;
  sample_t y;
  sample_t wr_data;
  logic [CMP_W-1:0] out_pos_ext;
  logic [CMP_W-1:0] out_len_ext;

  assign cmd       = in_tuser[CMD_W-1:0];
  assign blk_start = in_tuser[CMD_W];
  assign x         = in_tdata[SAMPLE_W-1:0];
  assign flag      = in_tdata[SAMPLE_W];

  // handshake: output register frees the read stage, read stage frees the input
  assign s1_fire   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_fire;
  assign in_fire   = in_tvalid && in_tready;

  // capacity limited to the memory depth, position arithmetic
  always_comb begin
    cap_eff = CMP_W'(cap_r);
    if (cap_eff > CMP_W'(LOOP_DEPTH)) begin
      cap_eff = CMP_W'(LOOP_DEPTH);
    end
    cnt_ext = CMP_W'(rec_cnt_r);
    pos_ext = CMP_W'(pos_r);
    fin_ext = CMP_W'(final_len_r);
    pos_inc = pos_ext + CMP_W'(1);
    pos_adv = (pos_inc >= fin_ext) ? '0 : AW'(pos_inc);
  end

  // command decode and control state update
  always_comb begin
    mode_nxt      = mode_r;
    mon_nxt       = mon_r;
    rec_cnt_nxt   = rec_cnt_r;
    final_len_nxt = final_len_r;
    pos_nxt       = pos_r;
    add_a         = '0;
    pb_en_a       = 1'b0;
    wr_a          = 1'b0;
    wr_odub_a     = 1'b0;
    addr_a        = pos_r;
    unique case (cmd)
      CMD_TICK: begin
        add_a   = mon_r ? x : '0;
        pb_en_a = (final_len_r != '0) && ((mode_r == MODE_PLAY) || (mode_r == MODE_ODUB))
                  && (pos_ext < fin_ext);
        if (mode_r == MODE_REC) begin
          if (cnt_ext < cap_eff) begin
            wr_a        = 1'b1;
            addr_a      = AW'(rec_cnt_r);
            rec_cnt_nxt = rec_cnt_r + CNT_W'(1);
          end
        end else if (mode_r == MODE_PLAY) begin
          if (final_len_r != '0) begin
            pos_nxt = pos_adv;
          end
        end else if (mode_r == MODE_ODUB) begin
          add_a = x;
          if ((final_len_r != '0) && (pos_ext < fin_ext)) begin
            wr_a      = 1'b1;
            wr_odub_a = 1'b1;
            pos_nxt   = pos_adv;
          end
        end
      end
      CMD_RECORD: begin
        if (mode_r == MODE_EMPTY) begin
          mode_nxt      = MODE_REC;
          rec_cnt_nxt   = '0;
          final_len_nxt = '0;
          pos_nxt       = '0;
        end
      end
      CMD_STOP: begin
        if (mode_r == MODE_REC) begin
          final_len_nxt = rec_cnt_r;
          pos_nxt       = '0;
          mode_nxt      = (rec_cnt_r != '0) ? MODE_STOP : MODE_EMPTY;
        end else if ((mode_r == MODE_PLAY) || (mode_r == MODE_ODUB)) begin
          pos_nxt  = '0;
          mode_nxt = MODE_STOP;
        end
      end
      CMD_PLAY: begin
        if ((mode_r == MODE_STOP) && (final_len_r != '0)) begin
          pos_nxt  = '0;
          mode_nxt = MODE_PLAY;
        end
      end
      CMD_OVERDUB: begin
        if (mode_r == MODE_PLAY) begin
          mode_nxt = MODE_ODUB;
        end else if (mode_r == MODE_ODUB) begin
          mode_nxt = MODE_PLAY;
        end
      end
      CMD_CLEAR: begin
        mode_nxt      = MODE_EMPTY;
        rec_cnt_nxt   = '0;
        final_len_nxt = '0;
        pos_nxt       = '0;
      end
      CMD_MONITOR: begin
        mon_nxt = flag;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_EMPTY;
      mon_r       <= 1'b0;
      rec_cnt_r   <= '0;
      final_len_r <= '0;
      pos_r       <= '0;
      cap_r       <= CAP_RESET;
    end else begin
      if (cfg_wen) begin
        cap_r <= cfg_wdata;
      end
      if (in_fire) begin
        mode_r      <= mode_nxt;
        mon_r       <= mon_nxt;
        rec_cnt_r   <= rec_cnt_nxt;
        final_len_r <= final_len_nxt;
        pos_r       <= pos_nxt;
      end
    end
  end

  // read stage payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_tick_r    <= (cmd == CMD_TICK);
      s1_bs_r      <= blk_start;
      s1_x_r       <= x;
      s1_add_r     <= add_a;
      s1_pb_en_r   <= pb_en_a;
      s1_wr_r      <= wr_a;
      s1_wr_odub_r <= wr_odub_a;
      s1_addr_r    <= addr_a;
      s1_mode_r    <= mode_nxt;
      s1_mon_r     <= mon_nxt;
      s1_final_r   <= final_len_nxt;
      s1_pos_r     <= pos_nxt;
    end
  end

  // playback sum, clamped; overdub writes it back
  always_comb begin
    pb      = s1_pb_en_r ? (fwd_r ? fwd_data_r : rd_data_r) : '0;
    y       = sat_sample(wide_sample_t'(pb) + wide_sample_t'(s1_add_r));
    wr_data = s1_wr_odub_r ? y : s1_x_r;
  end

  // memory port: read at the play position on transfer, write as the read stage leaves
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_data_r <= loop_mem[pos_r];
    end
    if (s1_fire && s1_wr_r) begin
      loop_mem[s1_addr_r] <= wr_data;
    end
  end

  // forward a write that lands on the entry being read in the same cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (in_fire) begin
      fwd_r <= s1_fire && s1_wr_r && (s1_addr_r == pos_r);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      fwd_data_r <= wr_data;
    end
  end

  // running peaks, restarted by block start
  always_comb begin
    in_peak_nxt  = s1_bs_r ? '0 : in_peak_r;
    out_peak_nxt = s1_bs_r ? '0 : out_peak_r;
    if (s1_tick_r) begin
      if (mag_sample(s1_x_r) > in_peak_nxt) begin
        in_peak_nxt = mag_sample(s1_x_r);
      end
      if (mag_sample(y) > out_peak_nxt) begin
        out_peak_nxt = mag_sample(y);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_peak_r  <= '0;
      out_peak_r <= '0;
    end else if (s1_fire) begin
      in_peak_r  <= in_peak_nxt;
      out_peak_r <= out_peak_nxt;
    end
  end

  // result packing
  always_comb begin
    out_pos_ext  = CMP_W'(s1_pos_r);
    out_len_ext  = CMP_W'(s1_final_r);
    out_data_nxt = '0;
    out_data_nxt[15:0]  = y;
    out_data_nxt[18:16] = s1_mode_r;
    out_data_nxt[34:19] = in_peak_nxt[SAMPLE_W-1:0];
    out_data_nxt[50:35] = out_peak_nxt[SAMPLE_W-1:0];
    out_data_nxt[70:51] = out_pos_ext[PLAYHD_W-1:0];
    out_data_nxt[91:71] = out_len_ext[LEN_W-1:0];
    out_data_nxt[92]    = s1_mon_r;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ hdl/alr_checker.sv @@
module alr_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [alr_pkg::OUT_DATA_W-1:0] out_tdata
);
  import alr_pkg::*;

  // a held result keeps its data
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // nothing comes out right after reset
  a_reset_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_tvalid)
    else $error("result valid right after reset");

  // no finalized loop means empty or recording
  a_len_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[91:71] == '0) |->
      (out_tdata[18:16] == MODE_EMPTY) || (out_tdata[18:16] == MODE_REC))
    else $error("loop mode without loop length");

  // playhead stays inside the loop, or at zero without one
  a_playhead: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      ((out_tdata[91:71] == '0) && (out_tdata[70:51] == '0)) ||
      (21'(out_tdata[70:51]) < out_tdata[91:71]))
    else $error("playhead outside loop");

endmodule

bind audio_loop_recorder_unit alr_checker u_alr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import alr_pkg::*;

  localparam int LOOP_DEPTH = 1048576;
  localparam int IDLE_LIMIT = 2000;
  localparam int LONG_HOLD  = 60;
  localparam int RAND_ITEMS = 1600;
  localparam int SMAX       = 32767;
  localparam int SMIN       = -32768;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

  typedef struct {
    logic [CMD_W-1:0]           cmd;
    logic signed [SAMPLE_W-1:0] smp;
    logic                       flag;
    logic                       block_start;
  } loop_item_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] out_sample;
    logic [STATE_W-1:0]         looper_state;
    logic [SAMPLE_W-1:0]        input_peak;
    logic [SAMPLE_W-1:0]        output_peak;
    logic [PLAYHD_W-1:0]        playhead;
    logic [LEN_W-1:0]           loop_length;
    logic                       monitoring;
  } looper_out_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wen = 1'b0;
  logic [CAP_W-1:0]      cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [IN_USER_W-1:0]  in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  audio_loop_recorder_unit #(.LOOP_DEPTH(LOOP_DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // looper state as the testbench sees it
  logic [STATE_W-1:0]         lp_mode = MODE_EMPTY;
  logic                       lp_monitor = 1'b0;
  int unsigned                lp_recorded = 0;
  int unsigned                lp_length = 0;
  int unsigned                lp_pos = 0;
  int unsigned                lp_in_peak = 0;
  int unsigned                lp_out_peak = 0;
  int unsigned                lp_capacity = CAP_RESET;
  logic signed [SAMPLE_W-1:0] lp_store [int unsigned];

  loop_item_t  pending_items[$];
  looper_out_t expected_outs[$];

  bit idle_on = 1'b1;
  bit hold_request = 1'b0;
  bit bus_loaded = 1'b0;
  int errors = 0;
  int items_queued = 0;
  int items_sent = 0;
  int results_checked = 0;
  int odub_ticks = 0;
  int clipped = 0;
  int sessions = 0;
  int cap_writes = 0;

  function automatic int clamp_sample(input int v);
    if (v > SMAX) return SMAX;
    if (v < SMIN) return SMIN;
    return v;
  endfunction

  function automatic int unsigned abs_sample(input int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic void wipe_loop();
    lp_mode = MODE_EMPTY;
    lp_recorded = 0;
    lp_length = 0;
    lp_pos = 0;
  endfunction

  function automatic void next_position();
    lp_pos = (lp_pos + 1 >= lp_length) ? 0 : lp_pos + 1;
  endfunction

  // advance the looper by one item and return the result it produces
  function automatic looper_out_t looper_step(input loop_item_t it);
    looper_out_t r;
    int x;
    int y;
    int mon;
    int pb;
    int total;
    int unsigned cap;
    x = int'(it.smp);
    y = 0;
    if (it.block_start) begin
      lp_in_peak = 0;
      lp_out_peak = 0;
    end
    case (it.cmd)
      CMD_TICK: begin
        mon = lp_monitor ? x : 0;
        pb = 0;
        if (lp_length > 0 && (lp_mode == MODE_PLAY || lp_mode == MODE_ODUB) &&
            lp_pos < lp_length && lp_store.exists(lp_pos))
          pb = int'(lp_store[lp_pos]);
        case (lp_mode)
          MODE_REC: begin
            cap = (lp_capacity > LOOP_DEPTH) ? LOOP_DEPTH : lp_capacity;
            if (lp_recorded < cap) begin
              lp_store[lp_recorded] = x[SAMPLE_W-1:0];
              lp_recorded++;
            end
            y = mon;
          end
          MODE_PLAY: begin
            total = pb + mon;
            y = clamp_sample(total);
            if (lp_length > 0) next_position();
          end
          MODE_ODUB: begin
            total = pb + x;
            y = clamp_sample(total);
            odub_ticks++;
            if (lp_length > 0 && lp_pos < lp_length) begin
              lp_store[lp_pos] = y[SAMPLE_W-1:0];
              next_position();
            end
          end
          default: y = mon;
        endcase
        if ((lp_mode == MODE_PLAY || lp_mode == MODE_ODUB) && total != y) clipped++;
        if (abs_sample(x) > lp_in_peak) lp_in_peak = abs_sample(x);
        if (abs_sample(y) > lp_out_peak) lp_out_peak = abs_sample(y);
      end
      CMD_RECORD: begin
        if (lp_mode == MODE_EMPTY) begin
          wipe_loop();
          lp_mode = MODE_REC;
        end
      end
      CMD_STOP: begin
        if (lp_mode == MODE_REC) begin
          lp_length = lp_recorded;
          lp_pos = 0;
          lp_mode = (lp_length > 0) ? MODE_STOP : MODE_EMPTY;
        end else if (lp_mode == MODE_PLAY || lp_mode == MODE_ODUB) begin
          lp_pos = 0;
          lp_mode = MODE_STOP;
        end
      end
      CMD_PLAY: begin
        if (lp_mode == MODE_STOP && lp_length > 0) begin
          lp_pos = 0;
          lp_mode = MODE_PLAY;
        end
      end
      CMD_OVERDUB: begin
        if (lp_mode == MODE_PLAY) lp_mode = MODE_ODUB;
        else if (lp_mode == MODE_ODUB) lp_mode = MODE_PLAY;
      end
      CMD_CLEAR: wipe_loop();
      CMD_MONITOR: lp_monitor = it.flag;
      default: ;
    endcase
    r.out_sample   = y[SAMPLE_W-1:0];
    r.looper_state = lp_mode;
    r.input_peak   = lp_in_peak[SAMPLE_W-1:0];
    r.output_peak  = lp_out_peak[SAMPLE_W-1:0];
    r.playhead     = lp_pos[PLAYHD_W-1:0];
    r.loop_length  = lp_length[LEN_W-1:0];
    r.monitoring   = lp_monitor;
    return r;
  endfunction

  function automatic void compare_field(input string name, input longint want,
                                        input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  function automatic void check_result(input looper_out_t got);
    looper_out_t want;
    if (expected_outs.size() == 0) begin
      $display("%0t: unexpected result transfer, expected none, actual %h", $time, out_tdata);
      errors++;
    end else begin
      want = expected_outs.pop_front();
      results_checked++;
      compare_field("out_sample", want.out_sample, got.out_sample);
      compare_field("looper_state", want.looper_state, got.looper_state);
      compare_field("input_peak", want.input_peak, got.input_peak);
      compare_field("output_peak", want.output_peak, got.output_peak);
      compare_field("playhead", want.playhead, got.playhead);
      compare_field("loop_length", want.loop_length, got.loop_length);
      compare_field("monitoring", want.monitoring, got.monitoring);
    end
  endfunction

  // sender: one item on the bus at a time, random gaps while idling is on
  loop_item_t on_bus;
  int in_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_outs.push_back(looper_step(on_bus));
        items_sent++;
        bus_loaded = 1'b0;
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_items.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
          in_gap = $urandom_range(0, 7);
          in_tvalid <= 1'b0;
        end else begin
          on_bus = pending_items.pop_front();
          bus_loaded = 1'b1;
          in_tvalid <= 1'b1;
          in_tdata <= {7'b0, on_bus.flag, on_bus.smp};
          in_tuser <= {on_bus.block_start, on_bus.cmd};
        end
      end
    end
  end

  // receiver: check each result transfer, stall in bursts or on a long hold
  looper_out_t seen;
  int out_stall = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        seen.out_sample   = out_tdata[15:0];
        seen.looper_state = out_tdata[18:16];
        seen.input_peak   = out_tdata[34:19];
        seen.output_peak  = out_tdata[50:35];
        seen.playhead     = out_tdata[70:51];
        seen.loop_length  = out_tdata[91:71];
        seen.monitoring   = out_tdata[92];
        check_result(seen);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall = LONG_HOLD;
      end
      if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 11) == 0) begin
        out_stall = $urandom_range(0, 7);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any transfer
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("[audio_loop_recorder_unit] ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic push_item(input logic [CMD_W-1:0] cmd, input int smp, input bit flag,
                           input bit bs);
    loop_item_t it;
    it.cmd = cmd;
    it.smp = smp[SAMPLE_W-1:0];
    it.flag = flag;
    it.block_start = bs;
    pending_items.push_back(it);
    items_queued++;
  endtask

  function automatic int rand_sample();
    case ($urandom_range(0, 15))
      0: return SMAX;
      1: return SMIN;
      2: return $urandom_range(0, 64) - 32;
      default: return int'($signed(16'($urandom)));
    endcase
  endfunction

  function automatic bit rand_bs();
    return $urandom_range(0, 15) == 0;
  endfunction

  // command item with random ignored fields
  task automatic push_cmd(input logic [CMD_W-1:0] cmd);
    push_item(cmd, rand_sample(), 1'($urandom_range(0, 1)), rand_bs());
  endtask

  task automatic push_ticks(input int n);
    repeat (n) push_item(CMD_TICK, rand_sample(), 1'($urandom_range(0, 1)), rand_bs());
  endtask

  // record a short loop, then play and overdub it
  task automatic add_session();
    int rounds;
    int n;
    sessions++;
    if ($urandom_range(0, 2) == 0) push_cmd(CMD_CLEAR);
    if ($urandom_range(0, 3) == 0) push_cmd(CMD_MONITOR);
    push_cmd(CMD_RECORD);
    push_ticks($urandom_range(0, 24));
    push_cmd(CMD_STOP);
    push_cmd(CMD_PLAY);
    rounds = $urandom_range(1, 4);
    repeat (rounds) begin
      n = $urandom_range(1, 30);
      repeat (n) begin
        case ($urandom_range(0, 29))
          0, 1, 2: push_cmd(CMD_OVERDUB);
          3:       push_cmd(CMD_MONITOR);
          default: push_ticks(1);
        endcase
      end
      if ($urandom_range(0, 3) == 0) begin
        push_cmd(CMD_STOP);
        push_cmd(CMD_PLAY);
      end
    end
    if ($urandom_range(0, 1) == 0) push_cmd(CMD_STOP);
  endtask

  task automatic add_noise(input int n);
    repeat (n) push_item(CMD_W'($urandom_range(0, 7)), rand_sample(),
                         1'($urandom_range(0, 1)), rand_bs());
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || bus_loaded || expected_outs.size() != 0)
      @(posedge clk);
  endtask

  // short random bursts near the target so the item count stays close to it
  task automatic fill_random(input int count);
    int target;
    target = items_queued + count;
    while (items_queued < target) begin
      if ((target - items_queued < 60) || $urandom_range(0, 5) == 0)
        add_noise($urandom_range(1, 6));
      else add_session();
    end
  endtask

  // capacity write while the looper is drained, pipeline settled
  task automatic write_capacity(input int unsigned v);
    repeat (4) @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= v[CAP_W-1:0];
    @(posedge clk);
    cfg_wen <= 1'b0;
    lp_capacity = v[CAP_W-1:0];
    cap_writes++;
  endtask

  // main sequence
  initial begin
    int unsigned caps[7];
    int per_phase;
    caps = '{1, 0, 2097151, 3, 1048576, 0, 0};
    caps[5] = $urandom_range(2, 40);
    caps[6] = $urandom_range(4, 30);
    per_phase = RAND_ITEMS / 7;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, ignored commands, saturation, empty recording
    push_item(CMD_TICK, SMAX, 0, 1);
    push_item(CMD_MONITOR, 0, 1, 0);
    push_item(CMD_TICK, SMIN, 0, 0);
    push_item(CMD_UNUSED, 12345, 1, 1);
    push_item(CMD_PLAY, SMIN, 1, 0);
    push_item(CMD_STOP, SMAX, 0, 0);
    push_item(CMD_OVERDUB, -1, 1, 0);
    push_item(CMD_RECORD, 0, 0, 0);
    push_item(CMD_TICK, SMAX, 1, 0);
    push_item(CMD_TICK, SMIN, 0, 0);
    push_item(CMD_TICK, 20000, 0, 0);
    push_item(CMD_TICK, -20000, 1, 0);
    push_item(CMD_RECORD, 7, 0, 0);
    push_item(CMD_STOP, 0, 0, 0);
    push_item(CMD_OVERDUB, 0, 0, 0);
    push_item(CMD_PLAY, 0, 0, 0);
    push_item(CMD_TICK, 1000, 0, 1);
    push_item(CMD_OVERDUB, 0, 0, 0);
    push_item(CMD_TICK, SMAX, 0, 0);
    push_item(CMD_TICK, SMIN, 0, 1);
    push_item(CMD_TICK, SMIN, 0, 0);
    push_item(CMD_TICK, SMAX, 0, 0);
    push_item(CMD_OVERDUB, 0, 0, 0);
    push_item(CMD_TICK, 0, 0, 0);
    push_item(CMD_STOP, 0, 0, 0);
    push_item(CMD_CLEAR, SMIN, 1, 0);
    push_item(CMD_MONITOR, SMAX, 0, 1);
    push_item(CMD_RECORD, 0, 0, 0);
    push_item(CMD_STOP, 0, 0, 0);
    wait_drained();

    // random phases, one capacity each; the sender pauses mid-phase until drained
    foreach (caps[i]) begin
      write_capacity(caps[i]);
      idle_on = (i != 6);
      if (i == 1) hold_request = 1'b1;
      fill_random(per_phase / 2);
      wait_drained();
      fill_random(per_phase - per_phase / 2);
      wait_drained();
    end

    repeat (8) @(posedge clk);
    $display("covered %0d items in %0d loop sessions over %0d capacity settings",
             items_sent, sessions, cap_writes);
    $display("checked %0d results, %0d overdub ticks, %0d clipped sums",
             results_checked, odub_ticks, clipped);
    if (errors == 0 && expected_outs.size() == 0) begin
      $display("[audio_loop_recorder_unit] OK");
    end else begin
      $display("[audio_loop_recorder_unit] ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/alr_pkg.sv
hdl/audio_loop_recorder_unit.sv
hdl/alr_checker.sv
tb/testbench.sv
